>>> design/bsoc_pkg.sv
package bsoc_pkg;

    // Serial multiplier: signed multiplicand, unsigned multiplier, one bit per cycle
    localparam int MCAND_W   = 19;
    localparam int MPLIER_W  = 16;
    localparam int ACC_W     = 34;
    localparam int MUL_STEPS = MPLIER_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // Serial restoring divider: one quotient bit per cycle
    localparam int NUM_W     = 29;
    localparam int DEN_W     = 18;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Field widths
    localparam int VOLT_W   = 13;
    localparam int CUR_W    = 16;
    localparam int RES_W    = 16;
    localparam int CHARGE_W = 15;
    localparam int STEP_W   = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam logic [STEP_W-1:0] RST_MIN_STEP = 15'd50;
    localparam logic [RES_W-1:0]  RST_MIN_RES  = 16'd10;
    localparam logic [RES_W-1:0]  RST_MAX_RES  = 16'd2000;
    localparam logic [CFG_W-1:0]  RST_RES_WT   = 16'd6554;
    localparam logic [CFG_W-1:0]  RST_CHG_WT   = 16'd3277;
    localparam logic [RES_W-1:0]  RST_DEF_RES  = 16'd150;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_STEP = 3'd0,
        CFG_MIN_RES  = 3'd1,
        CFG_MAX_RES  = 3'd2,
        CFG_RES_WT   = 3'd3,
        CFG_CHG_WT   = 3'd4,
        CFG_DEF_RES  = 3'd5
    } t_cfg_idx;

    // Open-circuit voltage curve, in microvolts, highest point first
    localparam int TABLE_POINTS = 13;
    localparam int SEGS  = TABLE_POINTS - 1;
    localparam int SEG_W = $clog2(SEGS);
    localparam int UV_W  = 23;

    localparam logic signed [ACC_W-1:0] OCV_TOP_UV = 34'sd4200000;
    localparam logic signed [ACC_W-1:0] OCV_BOT_UV = 34'sd3300000;
    localparam logic [CHARGE_W-1:0]     CHARGE_FULL = 15'd25600;

    // Per segment: low end of the voltage span, span width, charge step and
    // charge at the low end (charge in 1/256 percent)
    localparam logic [UV_W-1:0] SEG_LO [SEGS] = '{
        23'd4100000, 23'd4060000, 23'd3980000, 23'd3920000, 23'd3870000, 23'd3820000,
        23'd3790000, 23'd3750000, 23'd3700000, 23'd3600000, 23'd3500000, 23'd3300000
    };
    localparam logic [DEN_W-1:0] SEG_SPAN [SEGS] = '{
        18'd100000, 18'd40000, 18'd80000, 18'd60000, 18'd50000, 18'd50000,
        18'd30000,  18'd40000, 18'd50000, 18'd100000, 18'd100000, 18'd200000
    };
    localparam logic [11:0] SEG_DS [SEGS] = '{
        12'd1280, 12'd1280, 12'd2560, 12'd2560, 12'd2560, 12'd2560,
        12'd2560, 12'd2560, 12'd2560, 12'd2560, 12'd1280, 12'd1280
    };
    localparam logic [CHARGE_W-1:0] SEG_BASE [SEGS] = '{
        15'd24320, 15'd23040, 15'd20480, 15'd17920, 15'd15360, 15'd12800,
        15'd10240, 15'd7680,  15'd5120,  15'd2560,  15'd1280,  15'd0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RDIV,
        S_RCMP,
        S_REMA,
        S_OCVS,
        S_OCV,
        S_SEG,
        S_IMULS,
        S_IMUL,
        S_IDIV,
        S_CEMAS,
        S_CEMA,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0]        mplier;
        logic signed [ACC_W-1:0]    acc_init;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_st;

    // First segment whose low end is at or below the voltage; the caller
    // has already ruled out voltages outside the curve
    function automatic logic [SEG_W-1:0] seg_find(input logic [UV_W-1:0] ocv);
        logic [SEG_W-1:0] k;
        k = SEG_W'(SEGS - 1);
        for (int j = SEGS - 1; j >= 0; j--) begin
            if (ocv >= SEG_LO[j]) begin
                k = SEG_W'(j);
            end
        end
        return k;
    endfunction

endpackage

>>> design/bsoc_mul.sv
module bsoc_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bsoc_pkg::t_mul_req              i_req,
    output bsoc_pkg::t_unit_st              o_st,
    output logic signed [bsoc_pkg::ACC_W-1:0] o_acc
);
    import bsoc_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [MUL_CNT_W-1:0]    r_cnt;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_mcand;
    logic [MPLIER_W-1:0]     r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add: one multiplier bit per cycle, multiplicand walks left
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= i_req.acc_init;
            r_mcand  <= ACC_W'(i_req.mcand);
            r_mplier <= i_req.mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_acc     = r_acc;

endmodule

>>> design/bsoc_div.sv
module bsoc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsoc_pkg::t_div_req           i_req,
    output bsoc_pkg::t_unit_st           o_st,
    output logic [bsoc_pkg::NUM_W-1:0]   o_quo
);
    import bsoc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_quo     = r_num;

endmodule

>>> design/battery_soc_estimator.sv
// Battery state-of-charge estimator.
// Input items arrive on s_axis: voltage in mV and signed current in mA.
// Each item yields one result item on m_axis: filtered charge in 1/256
// percent and the internal resistance estimate in milliohms.
// Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata, one per
// cycle; the user must write them only while no item is in flight, since the
// block does not enforce it. Items are handled one at a time. The shortest
// path runs no resistance update, finds the open-circuit voltage off the curve
// and, for the first item, skips the charge filter; the longest runs the
// serial divider twice and the serial multiplier four times. s_axis_tready is
// high only between items, so the next item is taken in the cycle after the
// result register loads at the earliest.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver stalls, the following result waits in the
// last control step until the register frees.
// Reset (synchronous, active low) restores register defaults, clears the
// stored sample history and marks the next item as the first one.
module battery_soc_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // voltage_mv[12:0], cell_current[28:13], zero[31:29]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // charge_level[14:0], resistance_mohm[30:15], zero[31]
);
    import bsoc_pkg::*;

    // Configuration
    logic [STEP_W-1:0] r_min_step;
    logic [RES_W-1:0]  r_min_res;
    logic [RES_W-1:0]  r_max_res;
    logic [CFG_W-1:0]  r_res_wt;
    logic [CFG_W-1:0]  r_chg_wt;
    logic [RES_W-1:0]  r_def_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= RST_MIN_STEP;
            r_min_res  <= RST_MIN_RES;
            r_max_res  <= RST_MAX_RES;
            r_res_wt   <= RST_RES_WT;
            r_chg_wt   <= RST_CHG_WT;
            r_def_res  <= RST_DEF_RES;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MIN_STEP: r_min_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_MIN_RES:  r_min_res  <= i_cfg_wdata;
                CFG_MAX_RES:  r_max_res  <= i_cfg_wdata;
                CFG_RES_WT:   r_res_wt   <= i_cfg_wdata;
                CFG_CHG_WT:   r_chg_wt   <= i_cfg_wdata;
                CFG_DEF_RES:  r_def_res  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control and state
    t_state r_state, n_state;
    logic                    r_started, n_started;
    logic [VOLT_W-1:0]       r_prev_v, n_prev_v;
    logic [CUR_W-1:0]        r_prev_i, n_prev_i;
    logic [RES_W-1:0]        r_res, n_res;
    logic [CHARGE_W-1:0]     r_filt, n_filt;
    logic                    r_out_valid, n_out_valid;

    // Per-item working registers
    logic [VOLT_W-1:0]       r_volt, n_volt;
    logic [CUR_W-1:0]        r_cur, n_cur;
    logic [CUR_W:0]          r_di, n_di;
    logic [VOLT_W:0]         r_dv, n_dv;
    logic                    r_chk, n_chk;
    logic                    r_neg, n_neg;
    logic signed [ACC_W-1:0] r_ocv, n_ocv;
    logic [SEG_W-1:0]        r_seg, n_seg;
    logic [CHARGE_W-1:0]     r_inst, n_inst;
    logic [31:0]             r_out_data, n_out_data;

    t_mul_req                mul_req;
    t_unit_st                mul_st;
    logic signed [ACC_W-1:0] mul_acc;
    t_div_req                div_req;
    t_unit_st                div_st;
    logic [NUM_W-1:0]        div_quo;

    bsoc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_st    (mul_st),
        .o_acc   (mul_acc)
    );

    bsoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_st    (div_st),
        .o_quo   (div_quo)
    );

    logic [VOLT_W-1:0]   in_v;
    logic [CUR_W-1:0]    in_i;
    logic [CUR_W:0]      di_mag;
    logic [VOLT_W-1:0]   dv_mag;
    logic [UV_W-1:0]     dv_uv;
    logic [CUR_W:0]      res_diff;
    logic [CHARGE_W+1:0] chg_diff;
    logic [MCAND_W-1:0]  cur_ext;
    logic [UV_W-1:0]     volt_uv;
    logic [UV_W-1:0]     seg_off;

    assign in_v = s_axis_tdata[VOLT_W-1:0];
    assign in_i = s_axis_tdata[VOLT_W+CUR_W-1:VOLT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_prev_v    <= '0;
            r_prev_i    <= '0;
            r_res       <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_prev_v    <= n_prev_v;
            r_prev_i    <= n_prev_i;
            r_res       <= n_res;
            r_filt      <= n_filt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_volt     <= n_volt;
        r_cur      <= n_cur;
        r_di       <= n_di;
        r_dv       <= n_dv;
        r_chk      <= n_chk;
        r_neg      <= n_neg;
        r_ocv      <= n_ocv;
        r_seg      <= n_seg;
        r_inst     <= n_inst;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_prev_v    = r_prev_v;
        n_prev_i    = r_prev_i;
        n_res       = r_res;
        n_filt      = r_filt;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_volt      = r_volt;
        n_cur       = r_cur;
        n_di        = r_di;
        n_dv        = r_dv;
        n_chk       = r_chk;
        n_neg       = r_neg;
        n_ocv       = r_ocv;
        n_seg       = r_seg;
        n_inst      = r_inst;
        n_out_data  = r_out_data;
        mul_req     = '0;
        div_req     = '0;

        di_mag   = r_di[CUR_W] ? (CUR_W + 1)'(-r_di) : r_di;
        dv_mag   = r_dv[VOLT_W] ? VOLT_W'(-r_dv) : r_dv[VOLT_W-1:0];
        dv_uv    = UV_W'(dv_mag) * UV_W'(1000);
        res_diff = {1'b0, div_quo[RES_W-1:0]} - {1'b0, r_res};
        chg_diff = {2'b0, r_inst} - {2'b0, r_filt};
        cur_ext  = {{(MCAND_W - CUR_W){r_cur[CUR_W-1]}}, r_cur};
        volt_uv  = UV_W'(r_volt) * UV_W'(1000);
        seg_off  = r_ocv[UV_W-1:0] - SEG_LO[r_seg];

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_volt   = in_v;
                    n_cur    = in_i;
                    n_di     = {in_i[CUR_W-1], in_i} - {r_prev_i[CUR_W-1], r_prev_i};
                    n_dv     = {1'b0, in_v} - {1'b0, r_prev_v};
                    n_chk    = r_prev_v != '0;
                    n_prev_v = in_v;
                    n_prev_i = in_i;
                    if (!r_started) begin
                        n_res = r_def_res;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_chk && di_mag > {2'b0, r_min_step}) begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(dv_uv);
                    div_req.den   = DEN_W'(di_mag);
                    n_neg         = r_dv[VOLT_W] ^ r_di[CUR_W];
                    n_state       = S_RDIV;
                end else begin
                    n_state = S_OCVS;
                end
            end
            S_RDIV: begin
                if (div_st.done) begin
                    n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                // Negative candidates never pass
                if (!r_neg && div_quo > NUM_W'(r_min_res) && div_quo < NUM_W'(r_max_res)) begin
                    mul_req.start    = 1'b1;
                    mul_req.mcand    = MCAND_W'($signed(res_diff));
                    mul_req.mplier   = r_res_wt;
                    mul_req.acc_init = '0;
                    n_state          = S_REMA;
                end else begin
                    n_state = S_OCVS;
                end
            end
            S_REMA: begin
                if (mul_st.done) begin
                    n_res   = r_res + mul_acc[RES_W+15:16];
                    n_state = S_OCVS;
                end
            end
            S_OCVS: begin
                // Open-circuit voltage in uV: v*1000 - i*R
                mul_req.start    = 1'b1;
                mul_req.mcand    = -cur_ext;
                mul_req.mplier   = r_res;
                mul_req.acc_init = ACC_W'(volt_uv);
                n_state          = S_OCV;
            end
            S_OCV: begin
                if (mul_st.done) begin
                    n_ocv   = mul_acc;
                    n_state = S_SEG;
                end
            end
            S_SEG: begin
                priority if (r_ocv >= OCV_TOP_UV) begin
                    n_inst  = CHARGE_FULL;
                    n_state = S_CEMAS;
                end else if (r_ocv <= OCV_BOT_UV) begin
                    n_inst  = '0;
                    n_state = S_CEMAS;
                end else begin
                    n_seg   = seg_find(r_ocv[UV_W-1:0]);
                    n_state = S_IMULS;
                end
            end
            S_IMULS: begin
                mul_req.start    = 1'b1;
                mul_req.mcand    = {1'b0, seg_off[DEN_W-1:0]};
                mul_req.mplier   = MPLIER_W'(SEG_DS[r_seg]);
                mul_req.acc_init = '0;
                n_state          = S_IMUL;
            end
            S_IMUL: begin
                if (mul_st.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_acc[NUM_W-1:0];
                    div_req.den   = SEG_SPAN[r_seg];
                    n_state       = S_IDIV;
                end
            end
            S_IDIV: begin
                if (div_st.done) begin
                    n_inst  = SEG_BASE[r_seg] + div_quo[CHARGE_W-1:0];
                    n_state = S_CEMAS;
                end
            end
            S_CEMAS: begin
                // First item loads the filter directly
                if (!r_started) begin
                    n_filt    = r_inst;
                    n_started = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    mul_req.start    = 1'b1;
                    mul_req.mcand    = MCAND_W'($signed(chg_diff));
                    mul_req.mplier   = r_chg_wt;
                    mul_req.acc_init = '0;
                    n_state          = S_CEMA;
                end
            end
            S_CEMA: begin
                if (mul_st.done) begin
                    n_filt  = r_filt + mul_acc[CHARGE_W+15:16];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_res, r_filt};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_mul_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_st.busy)
        else $error("divider started while busy");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_st.busy && div_st.busy))
        else $error("multiplier and divider overlap");

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_st.done |-> (r_state == S_REMA || r_state == S_OCV ||
                         r_state == S_IMUL || r_state == S_CEMA))
        else $error("multiplier result arrived outside a wait step");

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[CHARGE_W-1:0] <= CHARGE_FULL)
        else $error("charge level above full scale");

endmodule
